/* sv/assert_macros.svh */
// assertion helpers for the solver RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* sv/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    typedef struct packed {
        logic signed [31:0] coef_quad;
        logic signed [31:0] coef_lin;
        logic signed [31:0] coef_const;
    } t_qrs_in;

    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] root_first;
        logic signed [31:0] root_second;
        logic               overflow;
    } t_qrs_out;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    localparam logic CFG_COEF_TOL = 1'b0;
    localparam logic CFG_DISC_TOL = 1'b1;

    // what a root divider lane must do with its quotient
    typedef struct packed {
        logic [1:0] count;
        logic       use1;
        logic       use2;
    } t_qrs_ctl;

endpackage

/* sv/qrs_div.sv */
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined signed fixed-point divider, one quotient bit per stage, with
// truncation toward zero and saturation to 32 bits.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [35:0] i_nmag,
    input  logic        i_nneg,
    input  logic [33:0] i_dmag,
    input  logic        i_dneg,
    output logic        o_valid,
    output logic [31:0] o_quot,
    output logic        o_ovf
);
    import qrs_pkg::*;

    // quotient bits: numerator is nmag<<FRAC_BITS, up to 36+FRAC_BITS bits
    localparam int NW = 36 + FRAC_BITS;
    localparam int DW = 34;

    logic [NW-1:0] r_num  [NW+1];
    logic [DW:0]   r_rem  [NW+1];
    logic [DW-1:0] r_den  [NW+1];
    logic          r_sgn  [NW+1];
    logic          r_nz   [NW+1];
    logic          r_dz   [NW+1];
    logic          r_vld  [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NW; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW:0] tr;
        r_num[0] <= {i_nmag, {FRAC_BITS{1'b0}}};
        r_rem[0] <= '0;
        r_den[0] <= i_dmag;
        r_sgn[0] <= i_nneg ^ i_dneg;
        r_nz[0]  <= (i_nmag == '0);
        r_dz[0]  <= (i_dmag == '0);
        for (int k = 1; k <= NW; k++) begin
            tr = {r_rem[k-1][DW-1:0], r_num[k-1][NW-1]};
            if (tr >= {1'b0, r_den[k-1]}) begin
                r_rem[k] <= tr - {1'b0, r_den[k-1]};
                r_num[k] <= {r_num[k-1][NW-2:0], 1'b1};
            end else begin
                r_rem[k] <= tr;
                r_num[k] <= {r_num[k-1][NW-2:0], 1'b0};
            end
            r_den[k] <= r_den[k-1];
            r_sgn[k] <= r_sgn[k-1];
            r_nz[k]  <= r_nz[k-1];
            r_dz[k]  <= r_dz[k-1];
        end
    end

    // num register holds the quotient after NW shifts
    logic [NW-1:0] q;
    assign q = r_num[NW];
    always_comb begin
        o_valid = r_vld[NW];
        o_ovf   = 1'b0;
        if (r_nz[NW]) begin
            o_quot = '0;
        end else if (r_dz[NW]) begin
            o_ovf  = 1'b1;
            o_quot = r_sgn[NW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!r_sgn[NW] || q == '0) begin
            if (q > NW'(32'h7FFF_FFFF)) begin
                o_ovf = 1'b1; o_quot = 32'h7FFF_FFFF;
            end else begin
                o_quot = q[31:0];
            end
        end else begin
            if (q > NW'(33'h0_8000_0000)) begin
                o_ovf = 1'b1; o_quot = 32'h8000_0000;
            end else begin
                o_quot = 32'(-q[31:0]);
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_sat_sign, i_clk, i_rst_n, o_valid && o_ovf,
        o_quot == 32'h8000_0000 || o_quot == 32'h7FFF_FFFF)
    `ASSERT_NEXT(a_vld_flow, i_clk, i_rst_n, i_valid, r_vld[0])
    `ASSERT_IMPL(a_zero_num, i_clk, i_rst_n, o_valid && r_nz[NW],
        o_quot == '0 && !o_ovf)
endmodule

/* sv/quadratic_root_solver.sv */
// Stages from the accepting edge to o_res_valid: 4 front stages, 35 square-root stages,
// 1 numerator stage, 37 + FRAC_BITS divider stages and the output register.
// Throughput: one item per cycle; busy stays low.
// Reset clears the valid pipeline and sets both tolerances to 1.
// Results appear for one cycle on o_res_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Pipelined solver of a*x^2+b*x+c=0 in signed fixed point.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  qrs_pkg::t_qrs_in   i_item,
    output logic               o_res_valid,
    output qrs_pkg::t_qrs_out  o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import qrs_pkg::*;

    localparam int SQW = 34;   // root bits of the discriminant square root

    // ---- configuration registers ------------------------------------------
    logic [15:0] r_coef_tol;
    logic [31:0] r_disc_tol;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_tol <= 16'd1;
            r_disc_tol <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_TOL: r_coef_tol <= i_cfg_data[15:0];
                CFG_DISC_TOL: r_disc_tol <= i_cfg_data;
                default:      r_coef_tol <= r_coef_tol;
            endcase
        end
    end

    // ---- stage 1: magnitudes and signs -------------------------------------
    logic        r1_v;
    logic [32:0] r1_am, r1_bm, r1_cm;
    logic        r1_an, r1_bn, r1_cn;

    function automatic logic [32:0] f_mag(input logic [31:0] v);
        return v[31] ? 33'(-{1'b1, v}) : {1'b0, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= start;
    end
    always_ff @(posedge i_clk) begin
        r1_am <= f_mag(i_item.coef_quad);
        r1_bm <= f_mag(i_item.coef_lin);
        r1_cm <= f_mag(i_item.coef_const);
        r1_an <= i_item.coef_quad[31];
        r1_bn <= i_item.coef_lin[31];
        r1_cn <= i_item.coef_const[31];
    end

    // ---- stage 2: products b*b and a*c, tolerance tests --------------------
    logic        r2_v;
    logic [65:0] r2_b2, r2_p;
    logic [32:0] r2_am, r2_bm, r2_cm;
    logic        r2_an, r2_bn, r2_cn, r2_alin, r2_bz, r2_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        r2_b2  <= r1_bm * r1_bm;
        r2_p   <= r1_am * r1_cm;
        r2_am  <= r1_am; r2_bm <= r1_bm; r2_cm <= r1_cm;
        r2_an  <= r1_an; r2_bn <= r1_bn; r2_cn <= r1_cn;
        r2_alin <= r1_am < {17'd0, r_coef_tol};
        r2_bz   <= r1_bm < {17'd0, r_coef_tol};
        r2_cz   <= r1_cm < {17'd0, r_coef_tol};
    end

    // ---- stage 3: discriminant magnitude and sign --------------------------
    logic        r3_v;
    logic [68:0] r3_d;
    logic        r3_dneg;
    logic [32:0] r3_am, r3_bm, r3_cm;
    logic        r3_an, r3_bn, r3_cn, r3_alin, r3_bz, r3_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        logic [68:0] b2w, p4;
        logic        acneg;
        b2w   = {3'd0, r2_b2};
        p4    = {1'b0, r2_p, 2'b00};
        acneg = (r2_an != r2_cn) && (r2_p != '0);
        if (acneg) begin
            r3_d <= b2w + p4; r3_dneg <= 1'b0;
        end else if (p4 <= b2w) begin
            r3_d <= b2w - p4; r3_dneg <= 1'b0;
        end else begin
            r3_d <= p4 - b2w; r3_dneg <= 1'b1;
        end
        r3_am <= r2_am; r3_bm <= r2_bm; r3_cm <= r2_cm;
        r3_an <= r2_an; r3_bn <= r2_bn; r3_cn <= r2_cn;
        r3_alin <= r2_alin; r3_bz <= r2_bz; r3_cz <= r2_cz;
    end

    // ---- stage 4: classify ---------------------------------------------------
    logic        r4_v;
    t_qrs_ctl    r4_ctl;
    logic [68:0] r4_d;
    logic [35:0] r4_n1;          // lane numerator: b-case or -c
    logic        r4_n1s;
    logic [33:0] r4_den;
    logic        r4_dns, r4_sq;
    logic signed [34:0] r4_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        t_qrs_ctl    ctl;
        logic [35:0] n1;
        logic        n1s;
        logic [33:0] den;
        logic        dns;
        logic        sq;
        ctl = '{count: CNT_NONE, use1: 1'b0, use2: 1'b0};
        n1  = '0;
        n1s = 1'b0;
        den = {r3_am, 1'b0};
        dns = r3_an;
        sq  = 1'b0;
        if (r3_alin) begin
            if (r3_bz) begin
                ctl.count = r3_cz ? CNT_INF : CNT_NONE;
            end else begin
                ctl = '{count: CNT_ONE, use1: 1'b1, use2: 1'b0};
                n1  = 36'(r3_cm); n1s = !r3_cn;
                den = {1'b0, r3_bm}; dns = r3_bn;
            end
        end else if (r3_d[68:32] == '0 && r3_d[31:0] < r_disc_tol) begin
            ctl = '{count: CNT_ONE, use1: 1'b1, use2: 1'b0};
            n1  = 36'(r3_bm); n1s = !r3_bn;
        end else if (!r3_dneg) begin
            ctl = '{count: CNT_TWO, use1: 1'b1, use2: 1'b1};
            sq  = 1'b1;
        end
        r4_d   <= r3_d;
        r4_nb  <= r3_bn ? 35'(r3_bm) : -35'(r3_bm);
        r4_ctl <= ctl;
        r4_n1  <= n1;
        r4_n1s <= n1s;
        r4_den <= den;
        r4_dns <= dns;
        r4_sq  <= sq;
    end

    // ---- square root: one root bit per stage ---------------------------------
    // D stays below 2^65, so its low 68 bits feed 34 digit steps.
    logic [34:0] r_sq_rem [SQW+1];
    logic [67:0] r_sq_d   [SQW+1];
    logic [33:0] r_sq_r   [SQW+1];
    logic        r_sq_v   [SQW+1];
    t_qrs_ctl    r_sq_ctl [SQW+1];
    logic [35:0] r_sq_n1  [SQW+1];
    logic        r_sq_n1s [SQW+1];
    logic [33:0] r_sq_den [SQW+1];
    logic        r_sq_dns [SQW+1];
    logic        r_sq_on  [SQW+1];
    logic signed [34:0] r_sq_nb [SQW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQW; k++) r_sq_v[k] <= 1'b0;
        end else begin
            r_sq_v[0] <= r4_v;
            for (int k = 1; k <= SQW; k++) r_sq_v[k] <= r_sq_v[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        logic [36:0] tr;
        logic [36:0] tt;
        r_sq_d[0] <= r4_d[67:0]; r_sq_r[0] <= '0; r_sq_rem[0] <= '0;
        r_sq_ctl[0] <= r4_ctl; r_sq_n1[0] <= r4_n1; r_sq_n1s[0] <= r4_n1s;
        r_sq_den[0] <= r4_den; r_sq_dns[0] <= r4_dns; r_sq_on[0] <= r4_sq;
        r_sq_nb[0] <= r4_nb;
        for (int k = 1; k <= SQW; k++) begin
            // bring down the next two bits of D, try a 1 as the next root bit
            tr = {r_sq_rem[k-1], r_sq_d[k-1][67:66]};
            tt = {1'b0, r_sq_r[k-1], 2'b01};
            if (tr >= tt) begin
                r_sq_rem[k] <= 35'(tr - tt);
                r_sq_r[k]   <= {r_sq_r[k-1][32:0], 1'b1};
            end else begin
                r_sq_rem[k] <= tr[34:0];
                r_sq_r[k]   <= {r_sq_r[k-1][32:0], 1'b0};
            end
            r_sq_d[k] <= {r_sq_d[k-1][65:0], 2'b00};
            r_sq_ctl[k] <= r_sq_ctl[k-1]; r_sq_n1[k] <= r_sq_n1[k-1];
            r_sq_n1s[k] <= r_sq_n1s[k-1]; r_sq_den[k] <= r_sq_den[k-1];
            r_sq_dns[k] <= r_sq_dns[k-1]; r_sq_on[k] <= r_sq_on[k-1];
            r_sq_nb[k] <= r_sq_nb[k-1];
        end
    end

    // ---- numerators for the two divider lanes -------------------------------
    logic        r5_v;
    t_qrs_ctl    r5_ctl;
    logic [35:0] r5_n1m, r5_n2m;
    logic        r5_n1s, r5_n2s;
    logic [33:0] r5_den;
    logic        r5_dns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r_sq_v[SQW];
    end
    always_ff @(posedge i_clk) begin
        logic signed [35:0] a1, a2;
        a1 = 36'(r_sq_nb[SQW]) + $signed({2'b0, r_sq_r[SQW]});
        a2 = 36'(r_sq_nb[SQW]) - $signed({2'b0, r_sq_r[SQW]});
        r5_ctl <= r_sq_ctl[SQW]; r5_den <= r_sq_den[SQW]; r5_dns <= r_sq_dns[SQW];
        if (r_sq_on[SQW]) begin
            r5_n1m <= a1[35] ? 36'(-a1) : 36'(a1); r5_n1s <= a1[35];
            r5_n2m <= a2[35] ? 36'(-a2) : 36'(a2); r5_n2s <= a2[35];
        end else begin
            r5_n1m <= r_sq_n1[SQW]; r5_n1s <= r_sq_n1s[SQW];
            r5_n2m <= '0;           r5_n2s <= 1'b0;
        end
    end

    // ---- divider lanes, control travels alongside ---------------------------
    localparam int DDEP = 36 + FRAC_BITS + 1;
    t_qrs_ctl r_ctl_dly [DDEP];
    always_ff @(posedge i_clk) begin
        r_ctl_dly[0] <= r5_ctl;
        for (int k = 1; k < DDEP; k++) r_ctl_dly[k] <= r_ctl_dly[k-1];
    end

    logic        d1_v, d2_v, d1_o, d2_o;
    logic [31:0] d1_q, d2_q;

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk, .i_rst_n, .i_valid(r5_v), .i_nmag(r5_n1m), .i_nneg(r5_n1s),
        .i_dmag(r5_den), .i_dneg(r5_dns), .o_valid(d1_v), .o_quot(d1_q), .o_ovf(d1_o));
    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
        .i_clk, .i_rst_n, .i_valid(r5_v), .i_nmag(r5_n2m), .i_nneg(r5_n2s),
        .i_dmag(r5_den), .i_dneg(r5_dns), .o_valid(d2_v), .o_quot(d2_q), .o_ovf(d2_o));

    // ---- output register ------------------------------------------------------
    t_qrs_ctl c_out;
    assign c_out = r_ctl_dly[DDEP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_res_valid <= 1'b0;
        else          o_res_valid <= d1_v;
    end
    always_ff @(posedge i_clk) begin
        o_res.root_count  <= c_out.count;
        o_res.root_first  <= c_out.use1 ? d1_q : '0;
        o_res.root_second <= c_out.use2 ? d2_q : '0;
        o_res.overflow    <= (c_out.use1 && d1_o) || (c_out.use2 && d2_o);
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_lanes_aligned, i_clk, i_rst_n, d1_v, d2_v)
    `ASSERT_IMPL(a_two_needs_both, i_clk, i_rst_n, d1_v && c_out.count == CNT_TWO,
        c_out.use1 && c_out.use2)
    `ASSERT_IMPL(a_absent_zero, i_clk, i_rst_n,
        o_res_valid && (o_res.root_count == CNT_NONE || o_res.root_count == CNT_INF),
        o_res.root_first == '0 && o_res.root_second == '0 && !o_res.overflow)
    `ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, start, !busy)
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic root solver: directed corner items,
// random coefficient sets across several tolerance settings, random idling,
// each result compared field by field against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    localparam int FB      = 16;
    localparam int LATENCY = 77 + FB;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_qrs_in     i_item;
    logic        o_res_valid;
    t_qrs_out    o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    // predictor copy of the tolerance registers
    logic [15:0] coef_tol;
    logic [31:0] disc_tol;

    t_qrs_out    root_queue[$];
    int          fail_count;
    int          result_count;
    int          idle_pct;

    quadratic_root_solver #(.FRAC_BITS(FB)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Signed divide (n << FB) / d, truncated toward zero, saturated to 32 bits.
    // Magnitudes fit in 36 bits, so 128-bit arithmetic never wraps.
    function automatic logic [31:0] sat_quot(input logic [63:0] nmag, input logic nneg,
                                             input logic [63:0] dmag, input logic dneg,
                                             inout logic ovf);
        logic [127:0] q;
        logic         neg;
        if (nmag == 0) return 32'd0;
        if (dmag == 0) begin
            ovf = 1'b1;
            return nneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        q   = ({64'd0, nmag} << FB) / {64'd0, dmag};
        neg = (nneg != dneg) && (q != 0);
        if (!neg) begin
            if (q > 128'h7FFF_FFFF) begin
                ovf = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return 32'd0 - q[31:0];
    endfunction

    // floor square root of a nonnegative value below 2^68
    function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int bit_i = 33; bit_i >= 0; bit_i--) begin
            c = r | (64'd1 << bit_i);
            if ({64'd0, c} * {64'd0, c} <= d) r = c;
        end
        return r;
    endfunction

    function automatic t_qrs_out solve_roots(input t_qrs_in it);
        t_qrs_out         r;
        logic             ovf;
        logic [63:0]      am, bm, cm, s;
        logic             an, bn, cn;
        logic signed [127:0] dsc;
        logic signed [63:0]  nb, n1, n2;
        an  = it.coef_quad[31];
        bn  = it.coef_lin[31];
        cn  = it.coef_const[31];
        am  = an ? 64'd0 - {{32{1'b1}}, it.coef_quad} : {32'd0, it.coef_quad};
        bm  = bn ? 64'd0 - {{32{1'b1}}, it.coef_lin} : {32'd0, it.coef_lin};
        cm  = cn ? 64'd0 - {{32{1'b1}}, it.coef_const} : {32'd0, it.coef_const};
        ovf = 1'b0;
        r   = '0;
        if (am < coef_tol) begin
            if (bm < coef_tol) begin
                r.root_count = (cm < coef_tol) ? CNT_INF : CNT_NONE;
            end else begin
                r.root_first = sat_quot(cm, !cn, bm, bn, ovf);
                r.root_count = CNT_ONE;
            end
        end else begin
            dsc = $signed({64'd0, bm * bm}) - 4 * $signed({64'd0, am * cm})
                  * ((an != cn) ? -1 : 1);
            if (dsc >= 0 && dsc < 0 + $signed({96'd0, disc_tol}) ||
                dsc < 0 && -dsc < $signed({96'd0, disc_tol})) begin
                r.root_first = sat_quot(bm, !bn, am << 1, an, ovf);
                r.root_count = CNT_ONE;
            end else if (dsc < 0) begin
                r.root_count = CNT_NONE;
            end else begin
                s  = floor_sqrt(dsc);
                nb = bn ? $signed(bm) : -$signed(bm);
                n1 = nb + $signed(s);
                n2 = nb - $signed(s);
                r.root_first  = sat_quot(n1 < 0 ? -n1 : n1, n1 < 0, am << 1, an, ovf);
                r.root_second = sat_quot(n2 < 0 ? -n2 : n2, n2 < 0, am << 1, an, ovf);
                r.root_count  = CNT_TWO;
            end
        end
        r.overflow = ovf;
        return r;
    endfunction

    // Send one item: idle at random first, then hold start until accepted.
    // Start stays high afterwards; the next idle cycle or drain drops it.
    task automatic send_item(input t_qrs_in it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        root_queue.push_back(solve_roots(it));
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_abc(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        t_qrs_in it;
        it.coef_quad  = a;
        it.coef_lin   = b;
        it.coef_const = c;
        send_item(it);
    endtask

    // Drain the pipe, then let the latency pass before touching registers.
    task automatic wait_drained();
        start <= 1'b0;
        while (root_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Hold the write until accepted; the caller drops valid afterwards.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_COEF_TOL) coef_tol = val[15:0];
        else disc_tol = val;
    endtask

    task automatic set_tolerances(input logic [15:0] ct, input logic [31:0] dt);
        wait_drained();
        write_reg(CFG_COEF_TOL, {16'd0, ct});
        write_reg(CFG_DISC_TOL, dt);
        i_cfg_valid <= 1'b0;
    endtask

    // extremes, the linear and degenerate branches, one and two roots, saturation
    task automatic test_directed();
        send_abc(32'h0, 32'h0, 32'h0);                 // infinitely many
        send_abc(32'h0, 32'h0, 32'h0001_0000);         // no roots, linear
        send_abc(32'h0, 32'h0002_0000, 32'hFFFC_0000); // x = 2
        send_abc(32'h0, 32'h0000_0001, 32'h7FFF_FFFF); // linear saturation
        send_abc(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000); // double root
        send_abc(32'h0001_0000, 32'h0, 32'h0001_0000);         // negative disc
        send_abc(32'h0001_0000, 32'h0, 32'hFFFC_0000);         // +-2
        send_abc(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_abc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_abc(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_abc(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000); // tiny a, huge roots
        send_abc(32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
        send_abc(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_abc(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        send_abc(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_tolerances(16'd0, 32'd0);                  // zero divisor now reachable
        send_abc(32'h0, 32'h0, 32'h0);
        send_abc(32'h0, 32'h0, 32'h0000_0005);
        send_abc(32'h0, 32'h0, 32'hFFFF_FFFB);
        send_abc(32'h0, 32'h0000_0003, 32'h0);
        send_abc(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(65535) - 32768;
            2: return $urandom_range(3) - 1;
            3: return $urandom_range(20) << 16;
            4: return {{12{$urandom_range(1) == 1}}, 20'($urandom())};
            default: return ($urandom_range(1) ? 32'h7FFF_FFF0 : 32'h8000_0000)
                            + $urandom_range(15);
        endcase
    endfunction

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            // build well-posed roots from integer factors one time in four
            if ($urandom_range(3) == 0) begin
                logic signed [31:0] r1, r2;
                r1 = $signed($urandom_range(40)) - 20;
                r2 = $signed($urandom_range(40)) - 20;
                send_abc(32'h0001_0000, -(r1 + r2) <<< 16, (r1 * r2) <<< 16);
            end else begin
                send_abc(rand_coef(), rand_coef(), rand_coef());
            end
        end
    endtask

    // no idling for a long burst, back-to-back at full rate
    task automatic test_burst();
        idle_pct = 0;
        test_random(300);
        idle_pct = 28;
    endtask

    // pause the sender until the pipe is empty, then resume
    task automatic test_drain_pause();
        test_random(50);
        start <= 1'b0;
        while (root_queue.size() != 0) @(posedge i_clk);
        test_random(50);
    endtask

    // check each result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (root_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                fail_count++;
            end else begin
                t_qrs_out e;
                e = root_queue.pop_front();
                result_count++;
                if (e.root_count !== o_res.root_count) begin
                    $display("%0t: root_count expected %0d actual %0d",
                             $time, e.root_count, o_res.root_count);
                    fail_count++;
                end
                if (e.root_first !== o_res.root_first) begin
                    $display("%0t: root_first expected %h actual %h",
                             $time, e.root_first, o_res.root_first);
                    fail_count++;
                end
                if (e.root_second !== o_res.root_second) begin
                    $display("%0t: root_second expected %h actual %h",
                             $time, e.root_second, o_res.root_second);
                    fail_count++;
                end
                if (e.overflow !== o_res.overflow) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, e.overflow, o_res.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        fail_count   = 0;
        result_count = 0;
        idle_pct     = 28;
        coef_tol     = 16'd1;
        disc_tol     = 32'd1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_COEF_TOL;
        i_cfg_data   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_tolerances(16'd1, 32'd1);
        test_random(400);
        test_burst();
        set_tolerances(16'hFFFF, 32'hFFFF_FFFF);
        test_random(300);
        set_tolerances(16'd256, 32'h0001_0000);
        test_drain_pause();
        set_tolerances(16'd0, 32'd0);
        test_random(300);
        set_tolerances(16'($urandom()), $urandom());
        test_random(250);
        set_tolerances(16'd1, 32'h0000_0100);
        test_random(250);

        start <= 1'b0;
        while (root_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Covered %0d results over six tolerance settings, extremes included,",
                 result_count);
        $display("with random idling, a full-rate burst and a drain pause.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
